[hw/rtl/vucrp_pkg.sv]
// Shared types and constants for the video unit CPU register port.
// Used by the register block, the sprite memory and the top level.
package vucrp_pkg;

	// Kind of input transaction
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_SRST  = 2'd3
	} op_t;

	// Register selects
	localparam logic [3:0] SEL_CTRL     = 4'd0;
	localparam logic [3:0] SEL_MASK     = 4'd1;
	localparam logic [3:0] SEL_STATUS   = 4'd2;
	localparam logic [3:0] SEL_OAM_ADDR = 4'd3;
	localparam logic [3:0] SEL_OAM_DATA = 4'd4;
	localparam logic [3:0] SEL_SCROLL   = 4'd5;
	localparam logic [3:0] SEL_ADDR     = 4'd6;
	localparam logic [3:0] SEL_DATA     = 4'd7;
	localparam logic [3:0] SEL_DMA      = 4'd8;

	localparam int SPR_AW = 8;

	localparam logic [16:0] WARMUP_RESET  = 17'd88974;
	localparam logic [16:0] TICK_MAX      = 17'h1FFFF;
	localparam logic [2:0]  STATUS_RESET  = 3'b101;
	localparam logic [2:0]  STATUS_VBLANK = 3'b100;
	localparam logic [15:0] PALETTE_LAST  = 16'h3EFF;
	localparam logic [15:0] STEP_ONE      = 16'd1;
	localparam logic [15:0] STEP_WIDE     = 16'd32;

	// Sprite memory access from the register block
	typedef struct packed {
		logic              we;
		logic              re;
		logic [SPR_AW-1:0] addr;
		logic [7:0]        wdata;
	} spr_req_t;

	// Result of one transaction; read_data is patched from the sprite
	// memory when spr_rd is set
	typedef struct packed {
		logic [7:0]  read_data;
		logic [13:0] next_vram_address;
		logic        vram_write_enable;
		logic [13:0] vram_write_address;
		logic [7:0]  vram_write_byte;
		logic        dma_request;
		logic [7:0]  dma_page;
		logic [7:0]  control_value;
		logic [7:0]  mask_value;
		logic [7:0]  scroll_x;
		logic [7:0]  scroll_y;
		logic        spr_rd;
	} res_t;

endpackage

[hw/rtl/video_unit_cpu_register_port_unit.sv]
// Video unit CPU register port: takes one transaction (register read or
// write, tick, soft reset) per clock unless the output stalls, and returns
// one result for each through stage s1 and an output register that holds
// the finished result while the next one sits in s1. All register state
// updates at acceptance; the sprite memory is a 256-byte synchronous RAM
// read at acceptance, so a sprite read result picks up its byte in stage
// s1. Sprite entries carry valid bits cleared by reset, so no clearing
// pass is needed. Depends on vucrp_pkg, vucrp_regs and vucrp_sprite_mem.
module video_unit_cpu_register_port_unit
	import vucrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] write_data, [15:8] vram_data, [23:16] vram_mirror_data
	input  logic [23:0] s_tdata,
	// [1:0] operation, [5:2] reg_select
	input  logic [5:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] read_data, [21:8] next_vram_address, [35:22] vram_write_address,
	// [43:36] vram_write_byte, [51:44] dma_page, [59:52] control_value,
	// [67:60] mask_value, [75:68] scroll_x, [83:76] scroll_y, [87:84] zero
	output logic [87:0] m_tdata,
	// [0] vram_write_enable, [1] dma_request
	output logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data
);

	logic     s_acc;
	logic     s1_adv;
	logic     s1_valid_q;
	res_t     res;
	res_t     res_s1;
	res_t     out_q;
	logic     out_valid_q;
	spr_req_t spr_req;
	logic [7:0] spr_rdata;

	assign cfg_ready = 1'b1;

	// Stage s1 moves on when the output register is free or being drained
	assign s1_adv   = !out_valid_q || m_tready;
	assign s_tready = !s1_valid_q || s1_adv;
	assign s_acc    = s_tvalid && s_tready;

	vucrp_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (s_acc),
		.op        (op_t'(s_tuser[1:0])),
		.sel       (s_tuser[5:2]),
		.wd        (s_tdata[7:0]),
		.vd        (s_tdata[15:8]),
		.vmd       (s_tdata[23:16]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_wdata (cfg_data),
		.res       (res),
		.spr_req   (spr_req)
	);

	vucrp_sprite_mem u_spr (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (spr_req),
		.rdata  (spr_rdata)
	);

	// Stage s1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	// Stage s1 payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			res_s1 <= res;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	// Output register payload, with the sprite byte merged in
	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			out_q <= res_s1;
			if (res_s1.spr_rd) begin
				out_q.read_data <= spr_rdata;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, out_q.scroll_y, out_q.scroll_x, out_q.mask_value,
		out_q.control_value, out_q.dma_page, out_q.vram_write_byte,
		out_q.vram_write_address, out_q.next_vram_address, out_q.read_data};
	assign m_tuser  = {out_q.dma_request, out_q.vram_write_enable};

	// A sprite data read must land in s1 flagged for the memory byte
	a_spr_rd_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tuser[1:0] == OP_READ && s_tuser[5:2] == SEL_OAM_DATA
		|=> s1_valid_q && res_s1.spr_rd)
		else $error("sprite read not tracked into s1");

	// No transaction is taken while both stages are full and the sink stalls
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && out_valid_q && !m_tready |-> !s_acc)
		else $error("input accepted with pipeline full");

	// A result never stores to video memory and requests DMA at once
	a_one_side_effect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.vram_write_enable && out_q.dma_request))
		else $error("store and DMA request in one result");

	// An accepted transaction occupies s1 in the next cycle
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> s1_valid_q)
		else $error("accepted transaction lost");

endmodule

[hw/rtl/vucrp_sprite_mem.sv]
// 256-byte sprite memory: synchronous RAM with registered read and per-entry
// valid bits so that unwritten entries read as zero. Depends on vucrp_pkg.
module vucrp_sprite_mem
	import vucrp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  spr_req_t   req,
	output logic [7:0] rdata
);

	logic [7:0]             mem [2**SPR_AW];
	logic [2**SPR_AW-1:0]   valid_q;
	logic [7:0]             rd_mem_q;
	logic                   rd_vld_q;

	// Mark entries as written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.we) begin
			valid_q[req.addr] <= 1'b1;
		end
	end

	// Store bytes
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
	end

	// Read port, held until the next read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_mem_q <= mem[req.addr];
			rd_vld_q <= valid_q[req.addr];
		end
	end

	assign rdata = rd_vld_q ? rd_mem_q : 8'h00;

endmodule

[hw/rtl/vucrp_regs.sv]
// Register state of the port: control, mask, status, scroll, address, buffer,
// bus byte, tick counter and warm-up setting. Depends on vucrp_pkg.
module vucrp_regs
	import vucrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  op_t         op,
	input  logic [3:0]  sel,
	input  logic [7:0]  wd,
	input  logic [7:0]  vd,
	input  logic [7:0]  vmd,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	output res_t        res,
	output spr_req_t    spr_req
);

	logic [7:0]  control_q, control_d;
	logic [7:0]  mask_q, mask_d;
	logic [2:0]  status_q, status_d;
	logic [7:0]  spr_addr_q, spr_addr_d;
	logic        toggle_q, toggle_d;
	logic [15:0] scroll_q, scroll_d;
	logic [15:0] vaddr_q, vaddr_d;
	logic [7:0]  rbuf_q, rbuf_d;
	logic [7:0]  bus_q, bus_d;
	logic [16:0] tick_q, tick_d;
	logic [16:0] warmup_q;
	logic        warm;
	logic [15:0] step;

	assign warm = tick_q < warmup_q;
	assign step = control_q[2] ? STEP_WIDE : STEP_ONE;

	// Decode the transaction and form next state and result
	always_comb begin
		control_d = control_q;
		mask_d    = mask_q;
		status_d  = status_q;
		spr_addr_d = spr_addr_q;
		toggle_d  = toggle_q;
		scroll_d  = scroll_q;
		vaddr_d   = vaddr_q;
		rbuf_d    = rbuf_q;
		bus_d     = bus_q;
		tick_d    = tick_q;
		res       = '0;
		spr_req   = '0;
		spr_req.addr  = spr_addr_q;
		spr_req.wdata = wd;
		if (acc) begin
			unique case (op)
				OP_READ: begin
					unique case (sel)
						SEL_STATUS: begin
							res.read_data = {status_q, bus_q[4:0]};
							status_d = status_q & ~STATUS_VBLANK;
							toggle_d = 1'b0;
						end
						SEL_OAM_DATA: begin
							spr_req.re = 1'b1;
							res.spr_rd = 1'b1;
							spr_addr_d = spr_addr_q + 8'd1;
						end
						SEL_DATA: begin
							if (vaddr_q <= PALETTE_LAST) begin
								res.read_data = rbuf_q;
								rbuf_d = vd;
							end else begin
								res.read_data = vd;
								rbuf_d = vmd;
							end
							vaddr_d = vaddr_q + step;
						end
						SEL_CTRL, SEL_MASK, SEL_OAM_ADDR, SEL_SCROLL, SEL_ADDR: begin
							res.read_data = bus_q;
						end
						default: begin
							res.read_data = 8'h00;
						end
					endcase
				end
				OP_WRITE: begin
					bus_d = wd;
					unique case (sel)
						SEL_CTRL: begin
							if (!warm) control_d = wd;
						end
						SEL_MASK: begin
							if (!warm) mask_d = wd;
						end
						SEL_OAM_ADDR: begin
							spr_addr_d = wd;
						end
						SEL_OAM_DATA: begin
							spr_req.we = 1'b1;
							spr_addr_d = spr_addr_q + 8'd1;
						end
						SEL_SCROLL: begin
							if (!warm) begin
								if (!toggle_q) scroll_d = {scroll_q[15:8], wd};
								else           scroll_d = {wd, scroll_q[7:0]};
								toggle_d = ~toggle_q;
							end
						end
						SEL_ADDR: begin
							if (!warm) begin
								if (!toggle_q) vaddr_d = {wd, vaddr_q[7:0]};
								else           vaddr_d = {vaddr_q[15:8], wd};
								toggle_d = ~toggle_q;
							end
						end
						SEL_DATA: begin
							res.vram_write_enable  = 1'b1;
							res.vram_write_address = vaddr_q[13:0];
							res.vram_write_byte    = wd;
							vaddr_d = vaddr_q + step;
						end
						SEL_DMA: begin
							res.dma_request = 1'b1;
							res.dma_page    = wd;
						end
						default: begin
							bus_d = wd;
						end
					endcase
				end
				OP_TICK: begin
					if (tick_q != TICK_MAX) tick_d = tick_q + 17'd1;
				end
				OP_SRST: begin
					tick_d    = '0;
					control_d = '0;
					mask_d    = '0;
					toggle_d  = 1'b0;
					scroll_d  = '0;
					rbuf_d    = '0;
				end
			endcase
		end
		res.next_vram_address = vaddr_d[13:0];
		res.control_value     = control_d;
		res.mask_value        = mask_d;
		res.scroll_x          = scroll_d[7:0];
		res.scroll_y          = scroll_d[15:8];
	end

	// Commit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q  <= '0;
			mask_q     <= '0;
			status_q   <= STATUS_RESET;
			spr_addr_q <= '0;
			toggle_q   <= 1'b0;
			scroll_q   <= '0;
			vaddr_q    <= '0;
			rbuf_q     <= '0;
			bus_q      <= '0;
			tick_q     <= '0;
		end else begin
			control_q  <= control_d;
			mask_q     <= mask_d;
			status_q   <= status_d;
			spr_addr_q <= spr_addr_d;
			toggle_q   <= toggle_d;
			scroll_q   <= scroll_d;
			vaddr_q    <= vaddr_d;
			rbuf_q     <= rbuf_d;
			bus_q      <= bus_d;
			tick_q     <= tick_d;
		end
	end

	// Warm-up setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q <= WARMUP_RESET;
		end else if (cfg_we) begin
			warmup_q <= cfg_wdata;
		end
	end

endmodule

[tb/register_port_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the video unit CPU register port: watches the input, result and
// warm-up channels, predicts every result and compares it field by field.
// Depends on vucrp_pkg for the operation codes, register selects and reset values.
module register_port_checker
	import vucrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// [7:0] write_data, [15:8] vram_data, [23:16] vram_mirror_data
	input  logic [23:0] s_tdata,
	// [1:0] operation, [5:2] reg_select
	input  logic [5:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] read_data, [21:8] next_vram_address, [35:22] vram_write_address,
	// [43:36] vram_write_byte, [51:44] dma_page, [59:52] control_value,
	// [67:60] mask_value, [75:68] scroll_x, [83:76] scroll_y, [87:84] zero
	input  logic [87:0] m_tdata,
	// [0] vram_write_enable, [1] dma_request
	input  logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [16:0] cfg_data,
	output int          mismatch_count,
	output int          results_outstanding
);

	typedef struct {
		logic [7:0]  read_byte;
		logic [13:0] next_addr;
		logic        store_en;
		logic [13:0] store_addr;
		logic [7:0]  store_byte;
		logic        dma_req;
		logic [7:0]  dma_page;
		logic [7:0]  ctrl;
		logic [7:0]  mask;
		logic [7:0]  scroll_lo;
		logic [7:0]  scroll_hi;
	} port_result_t;

	// Predicted register file of the port
	logic [16:0] warmup_ticks;
	logic [16:0] tick_total;
	logic [7:0]  ctrl_r;
	logic [7:0]  mask_r;
	logic [2:0]  status_bits;
	logic [7:0]  oam_addr;
	logic [7:0]  oam_mem [256];
	logic        second_write;
	logic [15:0] scroll_word;
	logic [15:0] vaddr;
	logic [7:0]  read_buf;
	logic [7:0]  bus_byte;

	port_result_t expected_port_results [$];
	port_result_t fresh;
	port_result_t oldest;

	initial mismatch_count = 0;

	task automatic clear_soft_state();
		tick_total = '0;
		ctrl_r = '0;
		mask_r = '0;
		second_write = 1'b0;
		scroll_word = '0;
		read_buf = '0;
	endtask

	// Apply one CPU access to the predicted state and build its result
	task automatic apply_cpu_access(input op_t op, input logic [3:0] sel,
			input logic [7:0] wd, input logic [7:0] vd, input logic [7:0] vmd,
			output port_result_t r);
		logic        warm;
		logic [15:0] stride;
		warm = tick_total < warmup_ticks;
		stride = ctrl_r[2] ? STEP_WIDE : STEP_ONE;
		r.read_byte = '0;
		r.store_en = 1'b0;
		r.store_addr = '0;
		r.store_byte = '0;
		r.dma_req = 1'b0;
		r.dma_page = '0;
		case (op)
			OP_READ: begin
				case (sel)
					SEL_STATUS: begin
						r.read_byte = {status_bits, bus_byte[4:0]};
						status_bits = status_bits & ~STATUS_VBLANK;
						second_write = 1'b0;
					end
					SEL_OAM_DATA: begin
						r.read_byte = oam_mem[oam_addr];
						oam_addr = oam_addr + 8'd1;
					end
					SEL_DATA: begin
						// palette range bypasses the buffer
						if (vaddr <= PALETTE_LAST) begin
							r.read_byte = read_buf;
							read_buf = vd;
						end else begin
							r.read_byte = vd;
							read_buf = vmd;
						end
						vaddr = vaddr + stride;
					end
					SEL_CTRL, SEL_MASK, SEL_OAM_ADDR, SEL_SCROLL, SEL_ADDR:
						r.read_byte = bus_byte;
					default:
						r.read_byte = '0;
				endcase
			end
			OP_WRITE: begin
				bus_byte = wd;
				case (sel)
					SEL_CTRL: if (!warm) ctrl_r = wd;
					SEL_MASK: if (!warm) mask_r = wd;
					SEL_OAM_ADDR: oam_addr = wd;
					SEL_OAM_DATA: begin
						oam_mem[oam_addr] = wd;
						oam_addr = oam_addr + 8'd1;
					end
					SEL_SCROLL: if (!warm) begin
						if (!second_write)
							scroll_word[7:0] = wd;
						else
							scroll_word[15:8] = wd;
						second_write = !second_write;
					end
					SEL_ADDR: if (!warm) begin
						if (!second_write)
							vaddr[15:8] = wd;
						else
							vaddr[7:0] = wd;
						second_write = !second_write;
					end
					SEL_DATA: begin
						r.store_en = 1'b1;
						r.store_addr = vaddr[13:0];
						r.store_byte = wd;
						vaddr = vaddr + stride;
					end
					SEL_DMA: begin
						r.dma_req = 1'b1;
						r.dma_page = wd;
					end
					default: ;
				endcase
			end
			OP_TICK: if (tick_total != TICK_MAX) tick_total = tick_total + 17'd1;
			default: clear_soft_state();
		endcase
		r.next_addr = vaddr[13:0];
		r.ctrl = ctrl_r;
		r.mask = mask_r;
		r.scroll_lo = scroll_word[7:0];
		r.scroll_hi = scroll_word[15:8];
	endtask

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			if (mismatch_count < 10)
				$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// Predict on input transactions, compare on result transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_soft_state();
			warmup_ticks = WARMUP_RESET;
			status_bits = STATUS_RESET;
			oam_addr = '0;
			for (int i = 0; i < 256; i++)
				oam_mem[i] = '0;
			vaddr = '0;
			bus_byte = '0;
			expected_port_results.delete();
			results_outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				warmup_ticks = cfg_data;
			if (s_tvalid && s_tready) begin
				apply_cpu_access(op_t'(s_tuser[1:0]), s_tuser[5:2], s_tdata[7:0],
					s_tdata[15:8], s_tdata[23:16], fresh);
				expected_port_results.push_back(fresh);
			end
			if (m_tvalid && m_tready) begin
				if (expected_port_results.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result transaction with nothing predicted", $time);
					mismatch_count++;
				end else begin
					oldest = expected_port_results.pop_front();
					check_field("read_data", 16'(oldest.read_byte), 16'(m_tdata[7:0]));
					check_field("next_vram_address", 16'(oldest.next_addr),
						16'(m_tdata[21:8]));
					check_field("vram_write_enable", 16'(oldest.store_en),
						16'(m_tuser[0]));
					check_field("vram_write_address", 16'(oldest.store_addr),
						16'(m_tdata[35:22]));
					check_field("vram_write_byte", 16'(oldest.store_byte),
						16'(m_tdata[43:36]));
					check_field("dma_request", 16'(oldest.dma_req), 16'(m_tuser[1]));
					check_field("dma_page", 16'(oldest.dma_page), 16'(m_tdata[51:44]));
					check_field("control_value", 16'(oldest.ctrl), 16'(m_tdata[59:52]));
					check_field("mask_value", 16'(oldest.mask), 16'(m_tdata[67:60]));
					check_field("scroll_x", 16'(oldest.scroll_lo), 16'(m_tdata[75:68]));
					check_field("scroll_y", 16'(oldest.scroll_hi), 16'(m_tdata[83:76]));
					check_field("tdata padding", 16'h0000, 16'(m_tdata[87:84]));
				end
			end
			results_outstanding <= expected_port_results.size();
		end
	end

endmodule

[tb/video_unit_cpu_register_port_unit_test.sv]
`timescale 1ns / 1ps
// Top of the register port testbench: clock, reset, stimulus, stalls and verdict.
// Depends on vucrp_pkg, the port RTL and register_port_checker.
module video_unit_cpu_register_port_unit_test
	import vucrp_pkg::*;
();

	localparam int          HOLD_CYCLES   = 400;
	localparam int          QUIET_LIMIT   = 3000;
	localparam logic [16:0] WARMUP_MAX    = 17'h1FFFF;
	localparam logic [3:0]  SEL_UNUSED    = 4'd15;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [7:0] write_data, [15:8] vram_data, [23:16] vram_mirror_data
	logic [23:0] s_tdata = '0;
	// [1:0] operation, [5:2] reg_select
	logic [5:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [7:0] read_data, [21:8] next_vram_address, [35:22] vram_write_address,
	// [43:36] vram_write_byte, [51:44] dma_page, [59:52] control_value,
	// [67:60] mask_value, [75:68] scroll_x, [83:76] scroll_y, [87:84] zero
	logic [87:0] m_tdata;
	// [0] vram_write_enable, [1] dma_request
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = '0;

	int mismatch_count;
	int results_outstanding;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int items_sent = 0;

	video_unit_cpu_register_port_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	register_port_checker port_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.s_tvalid            (s_tvalid),
		.s_tready            (s_tready),
		.s_tdata             (s_tdata),
		.s_tuser             (s_tuser),
		.m_tvalid            (m_tvalid),
		.m_tready            (m_tready),
		.m_tdata             (m_tdata),
		.m_tuser             (m_tuser),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_data            (cfg_data),
		.mismatch_count      (mismatch_count),
		.results_outstanding (results_outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Abort when no channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("video_unit_cpu_register_port_unit_test: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one access, idling first at random, and hold it until taken
	task automatic send_access(input op_t op, input logic [3:0] sel, input logic [7:0] wd);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {sel, op};
		s_tdata <= {8'($urandom), 8'($urandom), wd};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic random_access();
		int   pick;
		op_t  op;
		logic [3:0] sel;
		pick = $urandom_range(99);
		if (pick < 40)
			op = OP_READ;
		else if (pick < 80)
			op = OP_WRITE;
		else if (pick < 96)
			op = OP_TICK;
		else
			op = OP_SRST;
		sel = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
		send_access(op, sel, 8'($urandom));
	endtask

	// Mostly well-formed register sequences with random content
	task automatic random_traffic(input int count);
		int target;
		int kind;
		target = items_sent + count;
		while (items_sent < target) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				random_access();
			end else if (kind < 75) begin
				// address pair, then data port traffic
				send_access(OP_WRITE, SEL_ADDR,
					$urandom_range(1) ? 8'($urandom_range(63)) : 8'($urandom));
				send_access(OP_WRITE, SEL_ADDR, 8'($urandom));
				repeat ($urandom_range(4, 1))
					send_access($urandom_range(1) ? OP_READ : OP_WRITE, SEL_DATA,
						8'($urandom));
			end else if (kind < 87) begin
				send_access(OP_WRITE, SEL_SCROLL, 8'($urandom));
				send_access(OP_WRITE, SEL_SCROLL, 8'($urandom));
			end else if (kind < 95) begin
				repeat ($urandom_range(8, 1))
					send_access(OP_TICK, 4'($urandom), 8'($urandom));
			end else begin
				send_access(OP_READ, SEL_STATUS, 8'($urandom));
				random_access();
			end
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_outstanding != 0);
	endtask

	// Change the warm-up count only with the port idle
	task automatic set_warmup(input logic [16:0] ticks);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= ticks;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Still warming up: control, mask, scroll and address writes drop
		send_access(OP_READ, SEL_STATUS, 8'h00);
		send_access(OP_READ, SEL_STATUS, 8'h00);
		send_access(OP_WRITE, SEL_CTRL, 8'hFF);
		send_access(OP_WRITE, SEL_MASK, 8'hFF);
		send_access(OP_WRITE, SEL_SCROLL, 8'h7F);
		send_access(OP_WRITE, SEL_ADDR, 8'h3F);
		send_access(OP_READ, SEL_MASK, 8'h00);
		// sprite address wraps on data access
		send_access(OP_WRITE, SEL_OAM_ADDR, 8'hFF);
		send_access(OP_WRITE, SEL_OAM_DATA, 8'hA5);
		send_access(OP_WRITE, SEL_OAM_ADDR, 8'hFF);
		send_access(OP_READ, SEL_OAM_DATA, 8'h00);
		send_access(OP_READ, SEL_OAM_DATA, 8'h00);
		send_access(OP_WRITE, SEL_DMA, 8'hFF);
		send_access(OP_READ, SEL_DMA, 8'h00);
		send_access(OP_WRITE, SEL_UNUSED, 8'h81);
		send_access(OP_READ, SEL_UNUSED, 8'h00);
		send_access(OP_WRITE, SEL_STATUS, 8'hFF);
		send_access(OP_READ, SEL_STATUS, 8'h00);
		send_access(OP_WRITE, SEL_DATA, 8'hFF);
		send_access(OP_READ, SEL_DATA, 8'h00);
		send_access(OP_TICK, SEL_CTRL, 8'h00);
		send_access(OP_SRST, SEL_CTRL, 8'h00);

		// No warm-up: wide stride wraps past 0xFFFF, then the palette boundary
		set_warmup('0);
		send_access(OP_WRITE, SEL_CTRL, 8'h04);
		send_access(OP_WRITE, SEL_ADDR, 8'hFF);
		send_access(OP_WRITE, SEL_ADDR, 8'hFF);
		send_access(OP_READ, SEL_DATA, 8'h00);
		send_access(OP_WRITE, SEL_CTRL, 8'h00);
		send_access(OP_WRITE, SEL_ADDR, 8'h3E);
		send_access(OP_WRITE, SEL_ADDR, 8'hFF);
		send_access(OP_READ, SEL_DATA, 8'h00);
		send_access(OP_READ, SEL_DATA, 8'h00);
		send_access(OP_WRITE, SEL_SCROLL, 8'hFF);
		send_access(OP_WRITE, SEL_SCROLL, 8'h00);
		send_access(OP_WRITE, SEL_MASK, 8'hFF);
		send_access(OP_WRITE, SEL_CTRL, 8'hFF);
		send_access(OP_SRST, SEL_CTRL, 8'h00);

		// Slow result side
		tx_idle_pct = 6;
		rx_idle_pct <= 57;
		set_warmup('0);
		random_traffic(300);
		set_warmup(WARMUP_MAX);
		random_traffic(300);

		// Slow input side
		tx_idle_pct = 57;
		rx_idle_pct <= 6;
		set_warmup(17'($urandom_range(40, 1)));
		random_traffic(300);
		set_warmup(17'($urandom));
		random_traffic(300);

		// Full rate, with a long result stall so the input backs up
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		set_warmup(17'($urandom_range(16)));
		random_traffic(150);
		hold_requests <= hold_requests + 1;
		random_traffic(150);
		set_warmup(17'd1);
		random_traffic(300);

		// Soft reset restarts a short warm-up; writes take hold once it ends
		set_warmup(17'd6);
		send_access(OP_SRST, SEL_CTRL, 8'h00);
		repeat (2) begin
			send_access(OP_WRITE, SEL_CTRL, 8'h04);
			repeat (3) send_access(OP_TICK, 4'($urandom), 8'($urandom));
		end
		send_access(OP_WRITE, SEL_CTRL, 8'h04);
		send_access(OP_WRITE, SEL_MASK, 8'h1E);
		random_traffic(100);

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("video_unit_cpu_register_port_unit_test: done, clean");
		else
			$display("video_unit_cpu_register_port_unit_test: done, errors");
		$finish;
	end

endmodule

[video_unit_cpu_register_port_unit.f]
hw/rtl/vucrp_pkg.sv
hw/rtl/vucrp_sprite_mem.sv
hw/rtl/vucrp_regs.sv
hw/rtl/video_unit_cpu_register_port_unit.sv
tb/register_port_checker.sv
tb/video_unit_cpu_register_port_unit_test.sv
